>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the tick clock block.
// Each macro expands to one labeled concurrent assertion on clk, held off in rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a trigger in one cycle implies a condition in the next cycle.
`define ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

>>> rtl/tcs_pkg.sv
// Package for the tick clock with slew and load history.
// Holds default parameters, request codes and the controller state type.
package tcs_pkg;

  localparam int HISTORY_DEPTH_DEF = 8;
  localparam int UNIT_SECONDS_DEF  = 6;
  localparam int UPTIME_W          = 32;
  localparam int HZ_W              = 16;
  localparam logic [HZ_W-1:0] TICK_RATE_RESET = 16'd60;

  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_SET_WALL = 2'd1,
    REQ_SET_SLEW = 2'd2
  } req_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_MODIFY,
    S_EMIT
  } ctl_state_t;

endpackage

>>> rtl/tcs_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on nothing; the top level of the tick clock uses both.
interface tcs_req_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  req_type;
  logic        [31:0] new_wall_time;
  logic signed [31:0] new_slew_count;
  logic        [15:0] ready_count;

  modport source (output valid, req_type, new_wall_time, new_slew_count, ready_count,
                  input ready);
  modport sink (input valid, req_type, new_wall_time, new_slew_count, ready_count,
                output ready);
endinterface

interface tcs_rsp_if;
  logic               valid;
  logic               ready;
  logic        [31:0] uptime_now;
  logic        [31:0] wall_time_now;
  logic signed [31:0] slew_left;
  logic        [2:0]  slot_now;
  logic        [31:0] slot_load;

  modport source (output valid, uptime_now, wall_time_now, slew_left, slot_now, slot_load,
                  input ready);
  modport sink (input valid, uptime_now, wall_time_now, slew_left, slot_now, slot_load,
                output ready);
endinterface

>>> rtl/tick_clock_slew_load_history.sv
// Tick clock with wall-time slew and a load history store in one memory.
// A tick passes through the 32 steps of the bit-serial slot divider, the memory read,
// the modify-write and the emit; a set or ignored word skips the divide steps.
// A new word is taken only when idle, once the last one was emitted.
// Reset (rst, synchronous) clears uptime, wall time, slew, last slot, the history valid
// bits and the channel control; tick rate returns to 60 and takes effect at once.
`include "assert_macros.svh"

module tick_clock_slew_load_history
  import tcs_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int UNIT_SECONDS  = UNIT_SECONDS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [HZ_W-1:0] cfg_wdata,
  tcs_req_if.sink         req,
  tcs_rsp_if.source       rsp
);

  // Slot index width, divisor width (tick rate times unit seconds) and step count.
  localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int DIV_W  = HZ_W + $clog2(UNIT_SECONDS + 1);
  localparam int CNT_W  = $clog2(UPTIME_W);
  localparam int XW     = (SLOT_W > 3) ? SLOT_W : 3;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(UPTIME_W - 1);
  localparam logic [SLOT_W:0]  DEPTH_V   = (SLOT_W + 1)'(HISTORY_DEPTH);

  // Configuration and architectural state.
  logic [HZ_W-1:0]     tick_rate_hz;
  logic [UPTIME_W-1:0] uptime_count;
  logic [31:0]         wall_time;
  logic [31:0]         slew_count;
  logic [SLOT_W-1:0]   last_slot;

  // Word held while it is worked on.
  logic [1:0]          kind;
  logic [15:0]         ready_hold;

  // Serial divider: dividend shifts out MSB first, quotient bits fold into a
  // running residue mod HISTORY_DEPTH so the slot needs no second divide.
  logic [UPTIME_W-1:0] dividend;
  logic [DIV_W-1:0]    divisor;
  logic [DIV_W-1:0]    rem;
  logic [SLOT_W-1:0]   slot_acc;
  logic [CNT_W-1:0]    step_cnt;
  logic [DIV_W:0]      rem_shift;
  logic                q_bit;
  logic [SLOT_W:0]     acc_shift;
  logic [SLOT_W-1:0]   slot_acc_next;
  logic [HZ_W-1:0]     hz_eff;

  // History memory, its valid bits and read/modify/write signals.
  logic [31:0]              hist [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] hist_valid;
  logic [31:0]              rd_data;
  logic [SLOT_W-1:0]        mem_addr;
  logic [31:0]              old_load;
  logic [31:0]              new_load;
  logic [31:0]              load_val;
  logic                     is_tick;

  // Controller.
  ctl_state_t state, state_next;
  logic       accept;
  logic       div_step;
  logic       mem_re;
  logic       mem_we;
  logic       emit_fire;

  logic [UPTIME_W-1:0] up_inc;
  logic [XW-1:0]       slot_wide;

  assign accept  = req.valid && req.ready;
  assign is_tick = (kind == REQ_TICK);
  assign up_inc  = uptime_count + UPTIME_W'(1);
  assign hz_eff  = (tick_rate_hz == '0) ? HZ_W'(1) : tick_rate_hz;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (req.req_type == REQ_TICK) ? S_DIV : S_READ;
        end
      end
      S_DIV: begin
        if (step_cnt == LAST_STEP) begin
          state_next = S_READ;
        end
      end
      S_READ:   state_next = S_MODIFY;
      S_MODIFY: state_next = S_EMIT;
      S_EMIT: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    req.ready = 1'b0;
    div_step  = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    emit_fire = 1'b0;
    case (state)
      S_IDLE:   req.ready = 1'b1;
      S_DIV:    div_step  = 1'b1;
      S_READ:   mem_re    = 1'b1;
      S_MODIFY: mem_we    = is_tick;
      S_EMIT:   emit_fire = !rsp.valid || rsp.ready;
      default:  req.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate_hz <= TICK_RATE_RESET;
    end else if (cfg_we) begin
      tick_rate_hz <= cfg_wdata;
    end
  end

  // Apply the word to the clock state at acceptance; the response reads it at emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      uptime_count <= '0;
      wall_time    <= '0;
      slew_count   <= '0;
    end else if (accept) begin
      case (req.req_type)
        REQ_TICK: begin
          uptime_count <= up_inc;
          if (slew_count != '0 && up_inc[0]) begin
            if (!slew_count[31]) begin
              wall_time  <= wall_time + 32'd2;
              slew_count <= slew_count - 32'd1;
            end else begin
              slew_count <= slew_count + 32'd1;
            end
          end else begin
            wall_time <= wall_time + 32'd1;
          end
        end
        REQ_SET_WALL: wall_time  <= req.new_wall_time;
        REQ_SET_SLEW: slew_count <= req.new_slew_count;
        default: ;
      endcase
    end
  end

  // One restoring divide step plus one residue step per cycle.
  always_comb begin
    rem_shift     = {rem, dividend[UPTIME_W-1]};
    q_bit         = (rem_shift >= {1'b0, divisor});
    acc_shift     = {slot_acc, q_bit};
    slot_acc_next = (acc_shift >= DEPTH_V) ? SLOT_W'(acc_shift - DEPTH_V)
                                           : acc_shift[SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind       <= req.req_type;
      ready_hold <= req.ready_count;
      dividend   <= up_inc;
      divisor    <= DIV_W'(hz_eff) * DIV_W'(UNIT_SECONDS);
      rem        <= '0;
      slot_acc   <= '0;
      step_cnt   <= '0;
    end else if (div_step) begin
      rem      <= q_bit ? DIV_W'(rem_shift - {1'b0, divisor}) : rem_shift[DIV_W-1:0];
      dividend <= {dividend[UPTIME_W-2:0], 1'b0};
      slot_acc <= slot_acc_next;
      step_cnt <= step_cnt + CNT_W'(1);
    end
  end

  // Ticks address their new slot; other words read the last slot. The write of
  // one word lands before the next word can read, so no forwarding is needed.
  assign mem_addr = is_tick ? slot_acc : last_slot;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist[mem_addr] <= new_load;
    end
    if (mem_re) begin
      rd_data <= hist[mem_addr];
    end
  end

  // Entries never written since reset read as zero; a slot change starts fresh.
  always_comb begin
    old_load = hist_valid[mem_addr] ? rd_data : 32'd0;
    new_load = ((mem_addr != last_slot) ? 32'd0 : old_load) + 32'(ready_hold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= '0;
      last_slot  <= '0;
    end else if (mem_we) begin
      hist_valid[mem_addr] <= 1'b1;
      last_slot            <= mem_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MODIFY) begin
      load_val <= is_tick ? new_load : old_load;
    end
  end

  // Response register: hold the word until taken; a new word may start meanwhile.
  assign slot_wide = XW'(last_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (emit_fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      rsp.uptime_now    <= uptime_count;
      rsp.wall_time_now <= wall_time;
      rsp.slew_left     <= $signed(slew_count);
      rsp.slot_now      <= slot_wide[2:0];
      rsp.slot_load     <= load_val;
    end
  end

  // Checks.
  `ASSERT_NEXT(a_div_done, (state == S_DIV) && (step_cnt == LAST_STEP), state == S_READ, "divider did not hand over to the read")
  `ASSERT_NEXT(a_slot_marked, mem_we, hist_valid[$past(mem_addr)] && (last_slot == $past(mem_addr)), "written slot not marked valid or not made last")
  `ASSERT_CLK(a_uptime_src, ($past(rst) || $stable(uptime_count) || $past(accept && (req.req_type == REQ_TICK))), "uptime moved without a tick")
  `ASSERT_NEXT(a_emit_valid, emit_fire, rsp.valid && (state == S_IDLE), "emitted word not presented")

endmodule

>>> bench/tb_tick_clock_slew_load_history.sv
// Self-checking bench for tick_clock_slew_load_history: drives request words, predicts
// each reading in a small scoreboard class and compares it field by field.
// Depends on tcs_pkg, the tcs_req_if / tcs_rsp_if channel interfaces and the block itself.
module tb_tick_clock_slew_load_history;
  import tcs_pkg::*;

  // Block geometry as instantiated (package defaults).
  localparam int HIST_DEPTH = HISTORY_DEPTH_DEF;
  localparam int UNIT_SEC   = UNIT_SECONDS_DEF;

  // Request code the block must ignore.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Give up when nothing moves on either channel for this many cycles.
  localparam int QUIET_LIMIT = 3000;
  // Length of the long response stall that backs the block up.
  localparam int HOLD_CYCLES = 400;
  // Random words per idling phase.
  localparam int PHASE_WORDS = 670;
  // Settle time after the last reading, sized from the block's tick latency.
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic        [1:0]  req_type;
    logic        [31:0] new_wall_time;
    logic signed [31:0] new_slew_count;
    logic        [15:0] ready_count;
  } clock_request_t;

  typedef struct packed {
    logic        [31:0] uptime_now;
    logic        [31:0] wall_time_now;
    logic signed [31:0] slew_left;
    logic        [2:0]  slot_now;
    logic        [31:0] slot_load;
  } clock_reading_t;

  // Scoreboard: a private copy of the clock state plus the readings still owed.
  class clock_scoreboard;
    logic [15:0]    tick_rate;
    logic [31:0]    uptime;
    logic [31:0]    wall;
    logic [31:0]    slew;
    int unsigned    last_slot;
    logic [31:0]    history [HIST_DEPTH];
    clock_reading_t pending_readings[$];
    int             mismatches;

    function new();
      tick_rate = TICK_RATE_RESET;
      uptime    = '0;
      wall      = '0;
      slew      = '0;
      last_slot = 0;
      foreach (history[i]) history[i] = '0;
      mismatches = 0;
    endfunction

    // One clock tick: bump uptime, apply slew, then fold the ready count into its slot.
    function void advance_clock(logic [15:0] ready);
      logic [31:0] rate;
      int unsigned slot;
      uptime = uptime + 32'd1;
      if (slew != '0 && uptime[0]) begin
        if (!slew[31]) begin
          wall = wall + 32'd2;
          slew = slew - 32'd1;
        end else begin
          slew = slew + 32'd1;
        end
      end else begin
        wall = wall + 32'd1;
      end
      rate = (tick_rate == '0) ? 32'd1 : {16'd0, tick_rate};
      slot = ((uptime / rate) / UNIT_SEC) % HIST_DEPTH;
      if (slot != last_slot) begin
        history[slot] = '0;
        last_slot = slot;
      end
      history[slot] = history[slot] + {16'd0, ready};
    endfunction

    // Accepted request: update the state and queue the reading it must produce.
    function void note_request(clock_request_t w);
      clock_reading_t r;
      case (w.req_type)
        REQ_TICK:     advance_clock(w.ready_count);
        REQ_SET_WALL: wall = w.new_wall_time;
        REQ_SET_SLEW: slew = w.new_slew_count;
        default: ;
      endcase
      r.uptime_now    = uptime;
      r.wall_time_now = wall;
      r.slew_left     = slew;
      r.slot_now      = 3'(last_slot);
      r.slot_load     = history[last_slot];
      pending_readings.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        $error("%s: expected %08h, actual %08h", name, want, got);
      end
    endfunction

    function void check_reading(clock_reading_t got);
      clock_reading_t want;
      if (pending_readings.size() == 0) begin
        mismatches++;
        $error("reading arrived with no request outstanding");
        return;
      end
      want = pending_readings.pop_front();
      compare_field("uptime_now", want.uptime_now, got.uptime_now);
      compare_field("wall_time_now", want.wall_time_now, got.wall_time_now);
      compare_field("slew_left", want.slew_left, got.slew_left);
      compare_field("slot_now", {29'd0, want.slot_now}, {29'd0, got.slot_now});
      compare_field("slot_load", want.slot_load, got.slot_load);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  tcs_req_if req_ch();
  tcs_rsp_if rsp_ch();

  tick_clock_slew_load_history dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  clock_scoreboard board = new();

  // Idling odds in percent, changed only between phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // Raised by the stimulus thread; the response thread picks it up and stalls.
  bit          hold_request = 1'b0;
  int unsigned quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: count edges with no word moving on either channel.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tick_clock_slew_load_history regression: fail");
        $finish;
      end
    end
  end

  // Response side: check every accepted word, then pick ready for the next edge.
  // A hold request drops ready for a long stretch so the block backs up into its input.
  initial begin
    clock_reading_t got;
    int unsigned    hold_left;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.uptime_now    = rsp_ch.uptime_now;
        got.wall_time_now = rsp_ch.wall_time_now;
        got.slew_left     = rsp_ch.slew_left;
        got.slot_now      = rsp_ch.slot_now;
        got.slot_load     = rsp_ch.slot_load;
        board.check_reading(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic clock_request_t make_request(logic [1:0] kind, logic [31:0] wall_val,
                                                  logic [31:0] slew_val, logic [15:0] ready);
    clock_request_t w;
    w.req_type       = kind;
    w.new_wall_time  = wall_val;
    w.new_slew_count = slew_val;
    w.ready_count    = ready;
    return w;
  endfunction

  // Mostly ticks with small slews so the slew logic runs out and restarts often;
  // the rest loads wall time, hits the slew extremes or sends the unused code.
  function automatic clock_request_t random_request();
    clock_request_t w;
    int unsigned    pick;
    int             mag;
    pick = $urandom_range(99);
    if (pick < 70)      w.req_type = REQ_TICK;
    else if (pick < 82) w.req_type = REQ_SET_SLEW;
    else if (pick < 95) w.req_type = REQ_SET_WALL;
    else                w.req_type = REQ_UNUSED;
    w.new_wall_time = ($urandom_range(7) == 0) ? 32'hFFFF_FFF0 + $urandom_range(15)
                                               : $urandom();
    case ($urandom_range(9))
      0: w.new_slew_count = $urandom();
      1: w.new_slew_count = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: begin
        mag = $urandom_range(40);
        w.new_slew_count = $urandom_range(1) ? -mag : mag;
      end
    endcase
    case ($urandom_range(7))
      0: w.ready_count = 16'h0000;
      1: w.ready_count = 16'hFFFF;
      default: w.ready_count = 16'($urandom_range(16'hFFFF));
    endcase
    return w;
  endfunction

  // Offer one word, idling first at the phase's odds; hold it until accepted.
  task automatic send_request(input clock_request_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.req_type       <= w.req_type;
    req_ch.new_wall_time  <= w.new_wall_time;
    req_ch.new_slew_count <= w.new_slew_count;
    req_ch.ready_count    <= w.ready_count;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    board.note_request(w);
  endtask

  // Drop valid and wait until every owed reading has come back.
  task automatic drain_readings();
    req_ch.valid <= 1'b0;
    while (board.pending_readings.size() != 0) @(posedge clk);
  endtask

  // Write the tick rate while the block is idle; the scoreboard follows at once.
  task automatic write_tick_rate(input logic [15:0] rate);
    cfg_we    <= 1'b1;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.tick_rate = rate;
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) send_request(random_request());
  endtask

  initial begin
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_wdata             <= '0;
    req_ch.valid          <= 1'b0;
    req_ch.req_type       <= REQ_TICK;
    req_ch.new_wall_time  <= '0;
    req_ch.new_slew_count <= '0;
    req_ch.ready_count    <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Rate 0 counts as 1, so the slot moves every six ticks.
    write_tick_rate(16'h0000);
    send_request(make_request(REQ_TICK, '0, '0, 16'hFFFF));
    send_request(make_request(REQ_TICK, '0, '0, 16'h0000));
    // Wall time wraps past all ones.
    send_request(make_request(REQ_SET_WALL, 32'hFFFF_FFFE, '0, '0));
    send_request(make_request(REQ_TICK, '0, '0, 16'h0001));
    send_request(make_request(REQ_TICK, '0, '0, 16'h8000));
    // Positive slew of one: one fast tick on odd uptime, then back to normal.
    send_request(make_request(REQ_SET_SLEW, '0, 32'h0000_0001, '0));
    send_request(make_request(REQ_TICK, '0, '0, 16'h1234));
    send_request(make_request(REQ_TICK, '0, '0, 16'h4321));
    // Negative slew: wall time stalls on odd ticks while the count climbs to zero.
    send_request(make_request(REQ_SET_SLEW, '0, 32'hFFFF_FFFE, '0));
    repeat (4) send_request(make_request(REQ_TICK, '0, '0, 16'h00FF));
    // Slew at the most negative value.
    send_request(make_request(REQ_SET_SLEW, '0, 32'h8000_0000, '0));
    send_request(make_request(REQ_TICK, '0, '0, 16'hFF00));
    send_request(make_request(REQ_TICK, '0, '0, 16'h0F0F));
    // Slew at the most positive value.
    send_request(make_request(REQ_SET_SLEW, '0, 32'h7FFF_FFFF, '0));
    send_request(make_request(REQ_TICK, '0, '0, 16'hF0F0));
    send_request(make_request(REQ_TICK, '0, '0, 16'hAAAA));
    send_request(make_request(REQ_SET_SLEW, '0, 32'h0000_0000, '0));
    // Unused code: state reported untouched, whatever the other fields hold.
    send_request(make_request(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
    send_request(make_request(REQ_UNUSED, '0, '0, '0));
    send_request(make_request(REQ_SET_WALL, 32'h0000_0000, '0, '0));
    send_request(make_request(REQ_TICK, '0, '0, 16'hFFFF));
    send_request(make_request(REQ_TICK, '0, '0, 16'h5555));
    drain_readings();

    // Phase 1: slow slot clock turns the history over quickly; consumer mostly stalls.
    write_tick_rate(16'd2);
    send_idle_pct = 7;
    recv_idle_pct = 88;
    run_random(PHASE_WORDS);
    drain_readings();

    // Phase 2: widest rate, slot stays put; producer mostly idle.
    write_tick_rate(16'hFFFF);
    send_idle_pct = 88;
    recv_idle_pct = 7;
    run_random(PHASE_WORDS);
    drain_readings();

    // Phase 3: rate one, no idling, plus one long consumer stall to back the block up.
    write_tick_rate(16'd1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    run_random(PHASE_WORDS);
    drain_readings();

    // Let any stray reading show up before judging.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending_readings.size() == 0)
      $display("tick_clock_slew_load_history regression: pass");
    else
      $display("tick_clock_slew_load_history regression: fail");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/tcs_pkg.sv
rtl/tcs_if.sv
rtl/tick_clock_slew_load_history.sv
bench/tb_tick_clock_slew_load_history.sv
